/* rtl/hsv_pkg.sv */
`default_nettype none
package hsv_pkg;

	// Default channel width.
	localparam int CHANNEL_BITS = 8;

	// Hue scale: 1/64 degree units.
	localparam int HUE_W     = 15;
	localparam int HUE_SIXTH = 3840;
	localparam int HUE_FULL  = 23040;

	// Hue quotient never exceeds HUE_SIXTH, so it needs this many bits.
	localparam int HUE_QUO_BITS = 12;

	// Which channel holds the maximum.
	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// Per-pixel control that travels beside the divider.
	typedef struct packed {
		sector_t sector;
		logic    neg;
		logic    undef;
	} hsv_ctl_t;

	localparam int CTL_W = $bits(hsv_ctl_t);

endpackage
`default_nettype wire

/* rtl/rgb_to_hsv_converter.sv */
// Pixels pass in order through the front stages, the divider stages and the output register.
// Throughput: one pixel per clock; both dividers are fully pipelined, one quotient bit
// per stage, and the whole pipe advances whenever the output register is empty or taken.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
`default_nettype none
module rgb_to_hsv_converter #(
	parameter int CHANNEL_BITS = hsv_pkg::CHANNEL_BITS,
	parameter int IN_W  = ((3 * CHANNEL_BITS + 7) / 8) * 8,
	parameter int OUT_W = ((hsv_pkg::HUE_W + 2 * CHANNEL_BITS + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,  // red, green, blue (low to high)
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata,  // hue, saturation, brightness (low to high)
	output logic                  m_axis_tuser   // hue_undefined
);

	localparam int QUO_BITS = (CHANNEL_BITS > hsv_pkg::HUE_QUO_BITS) ?
		CHANNEL_BITS : hsv_pkg::HUE_QUO_BITS;
	localparam int NUM_W  = CHANNEL_BITS + QUO_BITS;
	localparam int SIDE_W = CHANNEL_BITS + hsv_pkg::CTL_W;
	localparam int HW     = hsv_pkg::HUE_W + 1;
	localparam int MAG_W  = hsv_pkg::HUE_QUO_BITS;

	logic                    en;
	logic                    valid_s2;
	logic [NUM_W-1:0]        num_hue_s2, num_sat_s2;
	logic [CHANNEL_BITS-1:0] den_hue_s2, den_sat_s2, max_s2;
	hsv_pkg::hsv_ctl_t       ctl_s2;

	logic                    div_valid;
	logic [QUO_BITS-1:0]     quo_hue, quo_sat;
	logic [SIDE_W-1:0]       div_side;
	logic [CHANNEL_BITS-1:0] div_max;
	hsv_pkg::hsv_ctl_t       div_ctl;

	logic [HW-1:0]           offset, mag, hue_sum;
	logic [hsv_pkg::HUE_W-1:0] hue_final;

	logic                       out_valid_q;
	logic [hsv_pkg::HUE_W-1:0]  hue_q;
	logic [CHANNEL_BITS-1:0]    sat_q, bright_q;
	logic                       undef_q;

	// Whole pipe moves when the output register can take a new pixel
	assign en            = ~out_valid_q | m_axis_tready;
	assign s_axis_tready = en;

	hsv_front #(
		.CHANNEL_BITS (CHANNEL_BITS),
		.NUM_W        (NUM_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_axis_tvalid),
		.red        (s_axis_tdata[CHANNEL_BITS-1:0]),
		.green      (s_axis_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
		.blue       (s_axis_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
		.valid_s2   (valid_s2),
		.num_hue_s2 (num_hue_s2),
		.den_hue_s2 (den_hue_s2),
		.num_sat_s2 (num_sat_s2),
		.den_sat_s2 (den_sat_s2),
		.max_s2     (max_s2),
		.ctl_s2     (ctl_s2)
	);

	hsv_div_pipe #(
		.CHANNEL_BITS (CHANNEL_BITS),
		.QUO_BITS     (QUO_BITS),
		.SIDE_W       (SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s2),
		.num_hue   (num_hue_s2),
		.den_hue   (den_hue_s2),
		.num_sat   (num_sat_s2),
		.den_sat   (den_sat_s2),
		.side_in   ({max_s2, ctl_s2}),
		.out_valid (div_valid),
		.quo_hue   (quo_hue),
		.quo_sat   (quo_sat),
		.side_out  (div_side)
	);

	assign div_max = div_side[SIDE_W-1:hsv_pkg::CTL_W];
	assign div_ctl = div_side[hsv_pkg::CTL_W-1:0];

	// Hue: sector offset plus or minus quotient, wrapped into one turn
	always_comb begin
		case (div_ctl.sector)
			hsv_pkg::SEC_RED:   offset = '0;
			hsv_pkg::SEC_GREEN: offset = HW'(2 * hsv_pkg::HUE_SIXTH);
			hsv_pkg::SEC_BLUE:  offset = HW'(4 * hsv_pkg::HUE_SIXTH);
			default:            offset = '0;
		endcase
		mag = HW'(quo_hue[MAG_W-1:0]);
		if (!div_ctl.neg) begin
			hue_sum = offset + mag;
		end else if (mag > offset) begin
			hue_sum = offset + HW'(hsv_pkg::HUE_FULL) - mag;
		end else begin
			hue_sum = offset - mag;
		end
		if (hue_sum >= HW'(hsv_pkg::HUE_FULL)) begin
			hue_sum = hue_sum - HW'(hsv_pkg::HUE_FULL);
		end
		hue_final = div_ctl.undef ? '0 : hue_sum[hsv_pkg::HUE_W-1:0];
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= div_valid;
		end
	end

	// Output register data
	always_ff @(posedge clk) begin
		if (en) begin
			hue_q    <= hue_final;
			sat_q    <= quo_sat[CHANNEL_BITS-1:0];
			bright_q <= div_max;
			undef_q  <= div_ctl.undef;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({bright_q, sat_q, hue_q});
	assign m_axis_tuser  = undef_q;

endmodule
`default_nettype wire

/* rtl/hsv_front.sv */
`default_nettype none
module hsv_front #(
	parameter int CHANNEL_BITS = hsv_pkg::CHANNEL_BITS,
	parameter int NUM_W        = 2 * CHANNEL_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire logic [CHANNEL_BITS-1:0] red,
	input  wire logic [CHANNEL_BITS-1:0] green,
	input  wire logic [CHANNEL_BITS-1:0] blue,
	output logic                         valid_s2,
	output logic [NUM_W-1:0]             num_hue_s2,
	output logic [CHANNEL_BITS-1:0]      den_hue_s2,
	output logic [NUM_W-1:0]             num_sat_s2,
	output logic [CHANNEL_BITS-1:0]      den_sat_s2,
	output logic [CHANNEL_BITS-1:0]      max_s2,
	output hsv_pkg::hsv_ctl_t            ctl_s2
);

	localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = {CHANNEL_BITS{1'b1}};

	logic [CHANNEL_BITS-1:0] mx, mn, op_a, op_b;
	hsv_pkg::sector_t        sector;

	logic                    valid_s1;
	logic [CHANNEL_BITS-1:0] max_s1, delta_s1, dmag_s1;
	hsv_pkg::sector_t        sector_s1;
	logic                    neg_s1;

	// Max, min and sector selection (red wins ties, then green)
	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (red == mx) begin
			sector = hsv_pkg::SEC_RED;
		end else if (green == mx) begin
			sector = hsv_pkg::SEC_GREEN;
		end else begin
			sector = hsv_pkg::SEC_BLUE;
		end
		case (sector)
			hsv_pkg::SEC_RED: begin
				op_a = green;
				op_b = blue;
			end
			hsv_pkg::SEC_GREEN: begin
				op_a = blue;
				op_b = red;
			end
			hsv_pkg::SEC_BLUE: begin
				op_a = red;
				op_b = green;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1: delta and signed difference as magnitude plus sign
	always_ff @(posedge clk) begin
		if (en) begin
			max_s1    <= mx;
			delta_s1  <= mx - mn;
			sector_s1 <= sector;
			neg_s1    <= (op_a < op_b);
			dmag_s1   <= (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);
		end
	end

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2: scaled numerators; zero divisors become one (numerator is zero then)
	always_ff @(posedge clk) begin
		if (en) begin
			num_hue_s2   <= NUM_W'(dmag_s1) * NUM_W'(hsv_pkg::HUE_SIXTH);
			num_sat_s2   <= NUM_W'(delta_s1) * NUM_W'(CHAN_MAX);
			den_hue_s2   <= (delta_s1 == '0) ? CHANNEL_BITS'(1) : delta_s1;
			den_sat_s2   <= (max_s1 == '0) ? CHANNEL_BITS'(1) : max_s1;
			max_s2       <= max_s1;
			ctl_s2.sector <= sector_s1;
			ctl_s2.neg    <= neg_s1;
			ctl_s2.undef  <= (delta_s1 == '0);
		end
	end

endmodule
`default_nettype wire

/* rtl/hsv_div_pipe.sv */
`default_nettype none
module hsv_div_pipe #(
	parameter int CHANNEL_BITS = hsv_pkg::CHANNEL_BITS,
	parameter int QUO_BITS     = hsv_pkg::HUE_QUO_BITS,
	parameter int SIDE_W       = CHANNEL_BITS + hsv_pkg::CTL_W
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             en,
	input  wire logic                             in_valid,
	input  wire logic [CHANNEL_BITS+QUO_BITS-1:0] num_hue,
	input  wire logic [CHANNEL_BITS-1:0]          den_hue,
	input  wire logic [CHANNEL_BITS+QUO_BITS-1:0] num_sat,
	input  wire logic [CHANNEL_BITS-1:0]          den_sat,
	input  wire logic [SIDE_W-1:0]                side_in,
	output logic                                  out_valid,
	output logic [QUO_BITS-1:0]                   quo_hue,
	output logic [QUO_BITS-1:0]                   quo_sat,
	output logic [SIDE_W-1:0]                     side_out
);

	localparam int NUM_W = CHANNEL_BITS + QUO_BITS;

	// Index 0 is the pipe input, index k the register after quotient step k.
	logic                    valid_s   [0:QUO_BITS];
	logic [NUM_W-1:0]        hrem_s    [0:QUO_BITS];
	logic [NUM_W-1:0]        srem_s    [0:QUO_BITS];
	logic [CHANNEL_BITS-1:0] hden_s    [0:QUO_BITS];
	logic [CHANNEL_BITS-1:0] sden_s    [0:QUO_BITS];
	logic [QUO_BITS-1:0]     hquo_s    [0:QUO_BITS];
	logic [QUO_BITS-1:0]     squo_s    [0:QUO_BITS];
	logic [SIDE_W-1:0]       side_s    [0:QUO_BITS];

	assign valid_s[0] = in_valid;
	assign hrem_s[0]  = num_hue;
	assign srem_s[0]  = num_sat;
	assign hden_s[0]  = den_hue;
	assign sden_s[0]  = den_sat;
	assign hquo_s[0]  = '0;
	assign squo_s[0]  = '0;
	assign side_s[0]  = side_in;

	// One restoring-division step per stage, both dividers side by side, MSB first
	for (genvar j = 0; j < QUO_BITS; j++) begin : g_step
		localparam int SH = QUO_BITS - 1 - j;

		logic [NUM_W-1:0] hsub, ssub;
		logic             hge, sge;

		assign hsub = NUM_W'(hden_s[j]) << SH;
		assign ssub = NUM_W'(sden_s[j]) << SH;
		assign hge  = (hrem_s[j] >= hsub);
		assign sge  = (srem_s[j] >= ssub);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else if (en) begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hrem_s[j+1] <= hge ? (hrem_s[j] - hsub) : hrem_s[j];
				srem_s[j+1] <= sge ? (srem_s[j] - ssub) : srem_s[j];
				hquo_s[j+1] <= {hquo_s[j][QUO_BITS-2:0], hge};
				squo_s[j+1] <= {squo_s[j][QUO_BITS-2:0], sge};
				hden_s[j+1] <= hden_s[j];
				sden_s[j+1] <= sden_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = valid_s[QUO_BITS];
	assign quo_hue   = hquo_s[QUO_BITS];
	assign quo_sat   = squo_s[QUO_BITS];
	assign side_out  = side_s[QUO_BITS];

endmodule
`default_nettype wire

/* bench/rgb_to_hsv_converter_tb.sv */
`timescale 1ns / 1ps

module rgb_to_hsv_converter_tb;

	localparam int IN_W  = 24;
	localparam int OUT_W = 32;

	// One converted pixel as it leaves the block
	typedef struct packed {
		logic [14:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
		logic        hue_undefined;
	} hsv_t;

	// Receiver stall patterns
	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_EVERY_FOURTH,
		SINK_SPARSE
	} sink_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;   // red, green, blue (low to high)
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;        // hue, saturation, brightness (low to high)
	logic              m_axis_tuser;        // hue_undefined

	logic [IN_W-1:0] pixel_queue[$];
	int              drain_marks[$];
	hsv_t            pending_hsv[$];

	int sent_count;
	int results_seen;
	int mismatches = 0;
	int burst_left = 1;
	int idle_left = 0;
	int mode_left = 0;
	int stall_tick = 0;
	int drain_pauses = 0;
	sink_mode_t sink_mode = SINK_OPEN;

	// coverage tallies
	int gray_count = 0;
	int black_count = 0;
	int red_third = 0;
	int green_third = 0;
	int blue_third = 0;
	int max_sat_count = 0;

	rgb_to_hsv_converter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [IN_W-1:0] rgb(int r, int g, int b);
		return {b[7:0], g[7:0], r[7:0]};
	endfunction

	// Append one pixel to the sender's queue
	function automatic void queue_pixel(logic [IN_W-1:0] px);
		pixel_queue = {pixel_queue, px};
	endfunction

	// Integer HSV of one pixel: max, delta*255/max, sector offset plus scaled diff
	function automatic hsv_t hsv_of_pixel(logic [IN_W-1:0] px);
		int unsigned r, g, b, mx, mn, delta, offs, pos, neg, mag, hue;
		hsv_pkg::sector_t sec;
		hsv_t res;
		r = px[7:0];
		g = px[15:8];
		b = px[23:16];
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = mx - mn;
		hue = 0;
		res.hue_undefined = (delta == 0);
		res.saturation = (mx == 0) ? 8'd0 : 8'((delta * 255) / mx);
		res.brightness = mx[7:0];
		if (delta != 0) begin
			// red wins ties, then green
			if (r == mx) sec = hsv_pkg::SEC_RED;
			else if (g == mx) sec = hsv_pkg::SEC_GREEN;
			else sec = hsv_pkg::SEC_BLUE;
			case (sec)
				hsv_pkg::SEC_RED: begin
					offs = 0;
					pos = g;
					neg = b;
				end
				hsv_pkg::SEC_GREEN: begin
					offs = 2 * hsv_pkg::HUE_SIXTH;
					pos = b;
					neg = r;
				end
				default: begin
					offs = 4 * hsv_pkg::HUE_SIXTH;
					pos = r;
					neg = g;
				end
			endcase
			if (pos >= neg) begin
				hue = offs + (hsv_pkg::HUE_SIXTH * (pos - neg)) / delta;
			end else begin
				mag = (hsv_pkg::HUE_SIXTH * (neg - pos)) / delta;
				hue = (mag > offs) ? offs + hsv_pkg::HUE_FULL - mag : offs - mag;
			end
			if (hue >= hsv_pkg::HUE_FULL) hue -= hsv_pkg::HUE_FULL;
		end
		res.hue = hue[14:0];
		return res;
	endfunction

	function automatic int near(int base);
		int v;
		v = base + $urandom_range(0, 4) - 2;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v;
	endfunction

	// Random pixel: mostly uniform, plus near-gray, tied maxima and extreme values
	function automatic logic [IN_W-1:0] random_pixel();
		int kind, base, lo, hi;
		int ends[4];
		ends = '{0, 1, 254, 255};
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			return IN_W'($urandom);
		end else if (kind < 8) begin
			base = $urandom_range(0, 255);
			return rgb(near(base), near(base), near(base));
		end else if (kind == 8) begin
			hi = $urandom_range(1, 255);
			lo = $urandom_range(0, hi);
			case ($urandom_range(0, 3))
				0: return rgb(hi, hi, lo);
				1: return rgb(hi, lo, hi);
				2: return rgb(lo, hi, hi);
				default: return rgb(hi, hi, hi);
			endcase
		end
		return rgb(ends[$urandom_range(0, 3)], ends[$urandom_range(0, 3)],
			ends[$urandom_range(0, 3)]);
	endfunction

	// Sender: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin : pixel_driver
		logic took;
		logic hold;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			sent_count <= 0;
		end else begin
			took = s_axis_tvalid && s_axis_tready;
			if (took) sent_count <= sent_count + 1;
			hold = drain_marks.size() > 0 && sent_count + took >= drain_marks[0];
			// pause point: wait until the pipe has delivered everything
			if (hold && !s_axis_tvalid && results_seen == sent_count) begin
				void'(drain_marks.pop_front());
				drain_pauses++;
				hold = 1'b0;
			end
			if (!s_axis_tvalid || took) begin
				if (hold || pixel_queue.size() == 0 || idle_left > 0) begin
					s_axis_tvalid <= 1'b0;
					if (idle_left > 0) idle_left--;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pixel_queue.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
							: $urandom_range(1, 16);
						idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// Receiver: stall pattern is picked anew at random intervals
	always @(posedge clk or negedge arst_n) begin : hsv_sink
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				sink_mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 300);
			end else begin
				mode_left--;
			end
			stall_tick++;
			case (sink_mode)
				SINK_OPEN:         m_axis_tready <= 1'b1;
				SINK_COIN:         m_axis_tready <= 1'($urandom_range(0, 1));
				SINK_EVERY_FOURTH: m_axis_tready <= (stall_tick % 4 == 0);
				default:           m_axis_tready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	// Monitor: check each output transaction, then predict each accepted input
	always @(posedge clk or negedge arst_n) begin : hsv_monitor
		hsv_t got;
		hsv_t want;
		if (!arst_n) begin
			results_seen <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen <= results_seen + 1;
				got.hue = m_axis_tdata[14:0];
				got.saturation = m_axis_tdata[22:15];
				got.brightness = m_axis_tdata[30:23];
				got.hue_undefined = m_axis_tuser;
				if (pending_hsv.size() == 0) begin
					if (mismatches < 10)
						$display("ERROR %0t: unexpected result hue=%0d sat=%0d val=%0d undef=%0b",
							$realtime, got.hue, got.saturation, got.brightness,
							got.hue_undefined);
					mismatches++;
				end else begin
					want = pending_hsv.pop_front();
					if (got.hue !== want.hue || got.saturation !== want.saturation ||
							got.brightness !== want.brightness ||
							got.hue_undefined !== want.hue_undefined) begin
						if (mismatches < 10)
							$display("ERROR %0t: hue %0d/%0d sat %0d/%0d val %0d/%0d undef %0b/%0b (exp/got)",
								$realtime, want.hue, got.hue, want.saturation, got.saturation,
								want.brightness, got.brightness, want.hue_undefined,
								got.hue_undefined);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = hsv_of_pixel(s_axis_tdata);
				pending_hsv = {pending_hsv, want};
				if (want.hue_undefined) gray_count++;
				else if (want.hue < 2 * hsv_pkg::HUE_SIXTH) red_third++;
				else if (want.hue < 4 * hsv_pkg::HUE_SIXTH) green_third++;
				else blue_third++;
				if (want.brightness == 0) black_count++;
				if (want.saturation == 8'd255) max_sat_count++;
			end
		end
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int n_directed;
		// black, white, gray, primaries, secondaries, ties, hue wrap below zero
		queue_pixel(rgb(0, 0, 0));
		queue_pixel(rgb(255, 255, 255));
		queue_pixel(rgb(128, 128, 128));
		queue_pixel(rgb(1, 1, 1));
		queue_pixel(rgb(255, 0, 0));
		queue_pixel(rgb(0, 255, 0));
		queue_pixel(rgb(0, 0, 255));
		queue_pixel(rgb(255, 255, 0));
		queue_pixel(rgb(0, 255, 255));
		queue_pixel(rgb(255, 0, 255));
		queue_pixel(rgb(255, 0, 1));
		queue_pixel(rgb(255, 1, 0));
		queue_pixel(rgb(1, 0, 0));
		queue_pixel(rgb(0, 1, 0));
		queue_pixel(rgb(0, 0, 1));
		queue_pixel(rgb(1, 1, 0));
		queue_pixel(rgb(0, 1, 1));
		queue_pixel(rgb(255, 254, 254));
		queue_pixel(rgb(254, 255, 255));
		queue_pixel(rgb(10, 20, 255));
		queue_pixel(rgb(255, 128, 0));
		queue_pixel(rgb(128, 255, 0));
		queue_pixel(rgb(0, 128, 255));
		queue_pixel(rgb(255, 0, 128));
		n_directed = pixel_queue.size();
		drain_marks = {drain_marks, n_directed};
		drain_marks = {drain_marks, n_directed + 200};
		repeat (400) queue_pixel(random_pixel());

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pixel_queue.size() > 0 || s_axis_tvalid || results_seen != sent_count)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (pending_hsv.size() != 0) begin
			$display("ERROR: %0d results never arrived", pending_hsv.size());
			mismatches++;
		end
		$display("Converted %0d pixels (%0d gray incl. %0d black, %0d full saturation),",
			sent_count, gray_count, black_count, max_sat_count);
		$display("hue thirds red/green/blue %0d/%0d/%0d, %0d drain pauses, %0d mismatches",
			red_third, green_third, blue_third, drain_pauses, mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* rgb_to_hsv_converter.f */
rtl/hsv_pkg.sv
rtl/hsv_front.sv
rtl/hsv_div_pipe.sv
rtl/rgb_to_hsv_converter.sv
bench/rgb_to_hsv_converter_tb.sv
